>>> hdl/sd3_pkg.sv
// Shared constants, types and helpers for the 3D diffusion stencil.
// Used by every module of the block but sd3_ram; depends on nothing else.
package sd3_pkg;

    // Grid limits and derived widths.
    localparam int MAX_GRID     = 64;
    localparam int MIN_GRID     = 3;
    localparam int GRID_FIELD_W = 7;
    localparam int N_W          = $clog2(MAX_GRID + 1);
    localparam int COORD_W      = $clog2(MAX_GRID);
    localparam int PLANE_W      = $clog2(MAX_GRID * MAX_GRID + 1);

    // Delay-line memories: long lines span about one plane, short ones one row.
    localparam int LONG_DEPTH  = MAX_GRID * MAX_GRID;
    localparam int LONG_AW     = $clog2(LONG_DEPTH);
    localparam int SHORT_DEPTH = MAX_GRID;
    localparam int SHORT_AW    = $clog2(SHORT_DEPTH);

    // Data formats.
    localparam int DATA_W    = 32;
    localparam int COEF_W    = 24;
    localparam int FRAC_BITS = 24;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] REG_COEF = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID = 1'd1;

    localparam logic [COEF_W-1:0]       COEF_RESET = 24'd16777;
    localparam logic [GRID_FIELD_W-1:0] GRID_RESET = 7'd64;

    // The seven window taps around the voxel being updated.
    typedef struct packed {
        logic signed [DATA_W-1:0] ctr;     // center voxel
        logic signed [DATA_W-1:0] up;      // next plane
        logic signed [DATA_W-1:0] dn;      // previous plane
        logic signed [DATA_W-1:0] nx_row;  // next row
        logic signed [DATA_W-1:0] pv_row;  // previous row
        logic signed [DATA_W-1:0] nx_col;  // next column
        logic signed [DATA_W-1:0] pv_col;  // previous column
    } sd3_taps_t;

    // Per-voxel flags that travel alongside the arithmetic.
    typedef struct packed {
        logic edge_voxel;
        logic last;
    } sd3_tag_t;

    // Clamp a written grid size to the supported range.
    function automatic logic [N_W-1:0] clamp_grid(input logic [GRID_FIELD_W-1:0] raw);
        logic [N_W-1:0] n;
        if (int'(raw) < MIN_GRID) begin
            n = N_W'(MIN_GRID);
        end else if (int'(raw) > MAX_GRID) begin
            n = N_W'(MAX_GRID);
        end else begin
            n = N_W'(raw);
        end
        return n;
    endfunction

endpackage

>>> hdl/sd3_ram.sv
// Generic single-clock RAM, one write port and one read port, registered read.
// A read and a write to the same address in one cycle return the old data.
// No dependencies.
module sd3_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Storage array with read-first behavior.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/sd3_window.sv
// Sliding window of two planes plus one voxel, built from four RAM delay lines
// and a few registers; presents the seven stencil taps. Uses sd3_pkg, sd3_ram.
module sd3_window
    import sd3_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     adv,
    input  logic                     restart,
    input  logic signed [DATA_W-1:0] sample,
    input  logic                     flush,
    input  logic [N_W-1:0]           grid_n,
    input  logic [PLANE_W-1:0]       plane,
    output sd3_taps_t                taps
);

    logic [DATA_W-1:0]  x_in;
    logic [DATA_W-1:0]  a_rdata, b_rdata, c_rdata, d_rdata;
    logic [DATA_W-1:0]  t0_reg, t3_reg, t4_reg;
    logic [LONG_AW-1:0] ptr_a_reg, ptr_a_next, ptr_d_reg, ptr_d_next;
    logic [SHORT_AW-1:0] ptr_s_reg, ptr_s_next;
    logic [PLANE_W-1:0] span;
    logic [LONG_AW-1:0] last_a, last_d;
    logic [SHORT_AW-1:0] last_s;

    // Flush words enter the window as zero.
    assign x_in = flush ? '0 : sample;

    // Line lengths: A is plane-N, D is plane-N-1, the short lines are N-2.
    assign span   = plane - PLANE_W'(grid_n);
    assign last_a = LONG_AW'(span - PLANE_W'(1));
    assign last_d = LONG_AW'(span - PLANE_W'(2));
    assign last_s = SHORT_AW'(grid_n - N_W'(3));

    // Circular pointers advance once per accepted word.
    always_comb begin
        ptr_a_next = (ptr_a_reg == last_a) ? '0 : ptr_a_reg + LONG_AW'(1);
        ptr_d_next = (ptr_d_reg == last_d) ? '0 : ptr_d_reg + LONG_AW'(1);
        ptr_s_next = (ptr_s_reg == last_s) ? '0 : ptr_s_reg + SHORT_AW'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            ptr_a_reg <= '0;
            ptr_d_reg <= '0;
            ptr_s_reg <= '0;
        end else if (adv) begin
            ptr_a_reg <= ptr_a_next;
            ptr_d_reg <= ptr_d_next;
            ptr_s_reg <= ptr_s_next;
        end
    end

    // Register taps: newest word, center and previous column.
    always_ff @(posedge aclk) begin
        if (adv) begin
            t0_reg <= x_in;
            t3_reg <= b_rdata;
            t4_reg <= t3_reg;
        end
    end

    // Newest word delayed to the next-row tap.
    sd3_ram #(.WIDTH(DATA_W), .DEPTH(LONG_DEPTH)) u_line_a (
        .aclk  (aclk),
        .we    (adv),
        .waddr (ptr_a_reg),
        .wdata (x_in),
        .re    (adv),
        .raddr (ptr_a_reg),
        .rdata (a_rdata)
    );

    // Next-row tap delayed to the next-column tap.
    sd3_ram #(.WIDTH(DATA_W), .DEPTH(SHORT_DEPTH)) u_line_b (
        .aclk  (aclk),
        .we    (adv),
        .waddr (ptr_s_reg),
        .wdata (a_rdata),
        .re    (adv),
        .raddr (ptr_s_reg),
        .rdata (b_rdata)
    );

    // Previous-column tap delayed to the previous-row tap.
    sd3_ram #(.WIDTH(DATA_W), .DEPTH(SHORT_DEPTH)) u_line_c (
        .aclk  (aclk),
        .we    (adv),
        .waddr (ptr_s_reg),
        .wdata (t4_reg),
        .re    (adv),
        .raddr (ptr_s_reg),
        .rdata (c_rdata)
    );

    // Previous-row tap delayed to the previous-plane tap.
    sd3_ram #(.WIDTH(DATA_W), .DEPTH(LONG_DEPTH)) u_line_d (
        .aclk  (aclk),
        .we    (adv),
        .waddr (ptr_d_reg),
        .wdata (c_rdata),
        .re    (adv),
        .raddr (ptr_d_reg),
        .rdata (d_rdata)
    );

    always_comb begin
        taps.up     = t0_reg;
        taps.nx_row = a_rdata;
        taps.nx_col = b_rdata;
        taps.ctr    = t3_reg;
        taps.pv_col = t4_reg;
        taps.pv_row = c_rdata;
        taps.dn     = d_rdata;
    end

endmodule

>>> hdl/sd3_update.sv
// Five-stage arithmetic pipeline with per-stage valid and stall handling:
// neighbor sum, Laplacian, coefficient multiply, shift, add and saturate.
// Uses sd3_pkg.
module sd3_update
    import sd3_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  sd3_taps_t                in_taps,
    input  sd3_tag_t                 in_tag,
    input  logic [COEF_W-1:0]        coef,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [DATA_W-1:0]        m_tdata,
    output logic                     m_tlast
);

    localparam int STAGES = 5;
    localparam int SUM2_W = DATA_W + 1;
    localparam int C6_W   = DATA_W + 3;
    localparam int SAB_W  = DATA_W + 2;
    localparam int DIFF_W = DATA_W + 4;
    localparam int PROD_W = DIFF_W + COEF_W + 1;
    localparam int SHR_W  = PROD_W - FRAC_BITS;
    localparam int ACC_W  = SHR_W + 1;

    logic [STAGES-1:0]        vld_reg;
    logic [STAGES-1:0]        en;
    sd3_tag_t                 tag_reg [STAGES];
    logic signed [DATA_W-1:0] ctr_reg [STAGES-1];

    logic signed [SUM2_W-1:0] pa_reg, pb_reg, pc_reg;
    logic signed [C6_W-1:0]   c6_reg;
    logic signed [SAB_W-1:0]  sab_reg;
    logic signed [DIFF_W-1:0] dcc_reg, diff_reg;
    logic signed [PROD_W-1:0] prod_reg, prod_shr;
    logic signed [SHR_W-1:0]  shr;
    logic signed [ACC_W-1:0]  acc;
    logic signed [C6_W-1:0]   c_ext;
    logic [DATA_W-1:0]        sat_val;
    logic [DATA_W-1:0]        out_reg;
    logic                     fits;

    // A stage may load when it is empty or its contents move on.
    always_comb begin
        en[STAGES-1] = !vld_reg[STAGES-1] || m_tready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign in_ready = en[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en[0]) begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (en[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // Flags and center value follow the data down the pipe.
    always_ff @(posedge aclk) begin
        if (en[0]) begin
            tag_reg[0] <= in_tag;
            ctr_reg[0] <= in_taps.ctr;
        end
        for (int k = 1; k < STAGES; k++) begin
            if (en[k]) begin
                tag_reg[k] <= tag_reg[k-1];
            end
        end
        for (int k = 1; k < STAGES - 1; k++) begin
            if (en[k]) begin
                ctr_reg[k] <= ctr_reg[k-1];
            end
        end
    end

    // Stage one: pairwise neighbor sums and six times the center.
    assign c_ext = C6_W'(in_taps.ctr);

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            pa_reg <= SUM2_W'(in_taps.up) + SUM2_W'(in_taps.dn);
            pb_reg <= SUM2_W'(in_taps.nx_row) + SUM2_W'(in_taps.pv_row);
            pc_reg <= SUM2_W'(in_taps.nx_col) + SUM2_W'(in_taps.pv_col);
            c6_reg <= (c_ext <<< 2) + (c_ext <<< 1);
        end
    end

    // Stage two: fold the sums toward the Laplacian.
    always_ff @(posedge aclk) begin
        if (en[1]) begin
            sab_reg <= SAB_W'(pa_reg) + SAB_W'(pb_reg);
            dcc_reg <= DIFF_W'(pc_reg) - DIFF_W'(c6_reg);
        end
    end

    // Stage three: full difference of neighbors and center.
    always_ff @(posedge aclk) begin
        if (en[2]) begin
            diff_reg <= DIFF_W'(sab_reg) + dcc_reg;
        end
    end

    // Stage four: multiply by the unsigned coefficient.
    always_ff @(posedge aclk) begin
        if (en[3]) begin
            prod_reg <= PROD_W'(diff_reg) * PROD_W'($signed({1'b0, coef}));
        end
    end

    // Stage five: floor shift, add the center and saturate to 32 bits; edge voxels give zero.
    always_comb begin
        prod_shr = prod_reg >>> FRAC_BITS;
        shr      = SHR_W'(prod_shr);
        acc      = ACC_W'(shr) + ACC_W'(ctr_reg[STAGES-2]);
        fits     = (acc[ACC_W-1:DATA_W-1] == '0) || (acc[ACC_W-1:DATA_W-1] == '1);
        if (fits) begin
            sat_val = acc[DATA_W-1:0];
        end else if (acc[ACC_W-1]) begin
            sat_val = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            sat_val = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            out_reg <= tag_reg[3].edge_voxel ? '0 : sat_val;
        end
    end

    assign m_tvalid = vld_reg[STAGES-1];
    assign m_tdata  = out_reg;
    assign m_tlast  = tag_reg[STAGES-1].last;

endmodule

>>> hdl/stencil_diffusion_3d_top.sv
// Seven-point 3D diffusion stencil, one Jacobi sweep over an N x N x N grid.
// Throughput: one word per cycle on both sides unless stalled; the first N*N
// words of a grid give no result, every later word gives one. A voxel's result
// passes the tap stage and update pipeline once the word one plane ahead is
// taken. Reset clears control state and restores the register defaults; the
// window memories are not cleared, and a grid size write restarts the stream.
module stencil_diffusion_3d_top
    import sd3_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [DATA_W-1:0]     s_tdata,    // [31:0] sample
    input  logic                  s_tuser,    // [0] flush
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [DATA_W-1:0]     m_tdata,    // [31:0] updated_value
    output logic                  m_tlast,    // last_voxel
    // Register writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [N_W-1:0]     N_RESET     = clamp_grid(GRID_RESET);
    localparam logic [PLANE_W-1:0] PLANE_RESET = PLANE_W'(N_RESET) * PLANE_W'(N_RESET);

    logic                 cfg_wr, grid_wr, adv, emit, upd_ready;
    logic [COEF_W-1:0]    coef_reg;
    logic [N_W-1:0]       n_reg, n_wr;
    logic [PLANE_W-1:0]   plane_reg, fill_reg;
    logic [COORD_W-1:0]   col_reg, row_reg, pln_reg, n_m1;
    logic                 v1_reg;
    sd3_tag_t             tag1_reg, tag_now;
    sd3_taps_t            taps;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign grid_wr   = cfg_wr && (cfg_index == REG_GRID);
    assign n_wr      = clamp_grid(cfg_data[GRID_FIELD_W-1:0]);

    // Configuration registers; the plane size is kept alongside the edge.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg  <= COEF_RESET;
            n_reg     <= N_RESET;
            plane_reg <= PLANE_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_index)
                REG_COEF: coef_reg <= cfg_data[COEF_W-1:0];
                REG_GRID: begin
                    n_reg     <= n_wr;
                    plane_reg <= PLANE_W'(n_wr) * PLANE_W'(n_wr);
                end
                default: ;
            endcase
        end
    end

    // Handshake: the tap stage frees up whenever the pipeline behind it moves.
    assign s_tready = !v1_reg || upd_ready;
    assign adv      = s_tvalid && s_tready;
    assign emit     = (fill_reg == plane_reg);
    assign n_m1     = COORD_W'(n_reg - N_W'(1));

    always_comb begin
        tag_now.edge_voxel = (pln_reg == '0) || (pln_reg == n_m1) ||
                             (row_reg == '0) || (row_reg == n_m1) ||
                             (col_reg == '0) || (col_reg == n_m1);
        tag_now.last       = (pln_reg == n_m1) && (row_reg == n_m1) && (col_reg == n_m1);
    end

    // Stream position: fill count for the first plane, then output coordinates.
    always_ff @(posedge aclk) begin
        if (!aresetn || grid_wr) begin
            fill_reg <= '0;
            col_reg  <= '0;
            row_reg  <= '0;
            pln_reg  <= '0;
        end else if (adv) begin
            if (!emit) begin
                fill_reg <= fill_reg + PLANE_W'(1);
            end else if (tag_now.last) begin
                fill_reg <= '0;
                col_reg  <= '0;
                row_reg  <= '0;
                pln_reg  <= '0;
            end else if (col_reg == n_m1) begin
                col_reg <= '0;
                if (row_reg == n_m1) begin
                    row_reg <= '0;
                    pln_reg <= pln_reg + COORD_W'(1);
                end else begin
                    row_reg <= row_reg + COORD_W'(1);
                end
            end else begin
                col_reg <= col_reg + COORD_W'(1);
            end
        end
    end

    // Tap stage valid and flags; the taps themselves live in the window.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= emit;
        end else if (upd_ready) begin
            v1_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            tag1_reg <= tag_now;
        end
    end

    sd3_window u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .restart (grid_wr),
        .sample  (s_tdata),
        .flush   (s_tuser),
        .grid_n  (n_reg),
        .plane   (plane_reg),
        .taps    (taps)
    );

    sd3_update u_update (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (v1_reg),
        .in_ready (upd_ready),
        .in_taps  (taps),
        .in_tag   (tag1_reg),
        .coef     (coef_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

>>> bench/testbench.sv
// Self-checking bench for stencil_diffusion_3d_top: raster voxel streams in, updated voxels out.
// Holds its own diffusion predictor in a scoreboard class; depends on sd3_pkg and the RTL.
`timescale 1ns / 1ps

module testbench
    import sd3_pkg::*;
();

    localparam int WINDOW_WORDS  = 2 * MAX_GRID * MAX_GRID + 1;
    localparam int SETTLE_CYCLES = 16;
    localparam int STALL_LIMIT   = 5000;
    localparam int RANDOM_WORDS  = 1080;
    localparam int MAX_GRID_WORDS = 80;
    localparam int LONG_HOLD     = 700;
    localparam int HOLD_AFTER    = 600;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [DATA_W-1:0]     s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [DATA_W-1:0]     m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // One expected output word.
    typedef struct {
        logic [DATA_W-1:0] value;
        logic              last;
    } voxel_update_t;

    // Diffusion predictor and store of the updates still owed by the block.
    class diffusion_scoreboard;
        logic [DATA_W-1:0]       window [WINDOW_WORDS];
        logic [COEF_W-1:0]       coef;
        logic [GRID_FIELD_W-1:0] grid_field;
        int unsigned             stream_pos;
        int unsigned             out_i, out_j, out_k;
        int unsigned             words_in, results_seen, failures;
        voxel_update_t           pending_updates[$];

        function new();
            foreach (window[p]) window[p] = '0;
            coef       = COEF_RESET;
            grid_field = GRID_RESET;
            words_in   = 0;
            results_seen = 0;
            failures   = 0;
            restart();
        endfunction

        function void restart();
            stream_pos = 0;
            out_i = 0;
            out_j = 0;
            out_k = 0;
        endfunction

        // Edge length in use; out-of-range writes are clamped.
        function int unsigned grid_edge();
            if (grid_field < MIN_GRID) return MIN_GRID;
            if (grid_field > MAX_GRID) return MAX_GRID;
            return grid_field;
        endfunction

        function longint tap(input int unsigned p);
            return longint'(signed'(window[p % WINDOW_WORDS]));
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
            if (idx == REG_COEF) begin
                coef = val[COEF_W-1:0];
            end else begin
                grid_field = val[GRID_FIELD_W-1:0];
                restart();
            end
        endfunction

        // Store one accepted word and work out the update it releases, if any.
        function void take_word(input logic [DATA_W-1:0] sample, input logic flush);
            int unsigned   n, plane, voxels, total, q;
            longint        centre, around, diff, upd;
            bit            boundary;
            voxel_update_t want;
            n      = grid_edge();
            plane  = n * n;
            voxels = plane * n;
            total  = voxels + plane;
            words_in++;
            window[stream_pos % WINDOW_WORDS] = flush ? '0 : sample;
            if (stream_pos >= plane) begin
                q = stream_pos - plane;
                boundary = (out_i == 0) || (out_i == n - 1) || (out_j == 0) ||
                           (out_j == n - 1) || (out_k == 0) || (out_k == n - 1);
                upd = 0;
                if (!boundary) begin
                    centre = tap(q);
                    around = tap(q + plane) + tap(q - plane) + tap(q + n) + tap(q - n) +
                             tap(q + 1) + tap(q - 1);
                    diff = around - 6 * centre;
                    upd  = centre + ((diff * longint'(coef)) >>> FRAC_BITS);
                    if (upd > 64'sd2147483647) upd = 64'sd2147483647;
                    if (upd < -64'sd2147483648) upd = -64'sd2147483648;
                end
                want.value = upd[DATA_W-1:0];
                want.last  = (q == voxels - 1);
                pending_updates.push_back(want);
                // Step the output coordinates in raster order.
                out_k++;
                if (out_k >= n) begin
                    out_k = 0;
                    out_j++;
                    if (out_j >= n) begin
                        out_j = 0;
                        out_i++;
                    end
                end
            end
            if (stream_pos + 1 >= total) begin
                restart();
            end else begin
                stream_pos++;
            end
        endfunction

        // Compare one output word with the oldest update owed.
        function void check_result(input logic [DATA_W-1:0] value, input logic last);
            voxel_update_t want;
            results_seen++;
            if (pending_updates.size() == 0) begin
                $error("unexpected output word: updated_value %h, last_voxel %b", value, last);
                failures++;
                return;
            end
            want = pending_updates.pop_front();
            if (value !== want.value) begin
                $error("updated_value mismatch: expected %h, actual %h", want.value, value);
                failures++;
            end
            if (last !== want.last) begin
                $error("last_voxel mismatch: expected %b, actual %b", want.last, last);
                failures++;
            end
        endfunction
    endclass

    diffusion_scoreboard stencil_sb;
    int unsigned         burst_left = 0;
    int unsigned         idle_cycles = 0;

    stencil_diffusion_3d_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Watchdog: ends the run when no channel has moved a word for too long.
    always @(posedge aclk) begin
        if (aresetn === 1'b1) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("testbench NOT OK");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Result side: checks every accepted word and stalls on a pattern of its own,
    // with one long hold-off so that the block backs up into its input.
    initial begin : result_sink
        int unsigned mode, mode_left, hold_left, tick;
        bit          held;
        logic        ready_next;
        mode = 0;
        mode_left = 0;
        hold_left = 0;
        tick = 0;
        held = 1'b0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                stencil_sb.check_result(m_tdata, m_tlast);
            end
            if (!held && stencil_sb.words_in >= HOLD_AFTER) begin
                held = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (mode_left == 0) begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 200);
            end
            mode_left--;
            tick++;
            if (hold_left != 0) begin
                hold_left--;
                ready_next = 1'b0;
            end else begin
                case (mode)
                    0: ready_next = 1'b1;
                    1: ready_next = ($urandom_range(0, 1) == 0);
                    2: ready_next = ($urandom_range(0, 3) != 0);
                    default: ready_next = (tick % 5 != 0);
                endcase
            end
            m_tready <= ready_next;
        end
    end

    // Offer one word, with burst gaps in front of it, and wait for it to be taken.
    task automatic send_word(input logic [DATA_W-1:0] val, input logic flush);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400)
                                                     : $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= val;
        s_tuser  <= flush;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        stencil_sb.take_word(val, flush);
    endtask

    // Random voxel stream: mostly well-formed, with now and then a flush flag flipped.
    task automatic send_stream(input int unsigned count);
        int unsigned       n, idx;
        logic              flush;
        logic [DATA_W-1:0] val;
        n = stencil_sb.grid_edge();
        for (idx = 0; idx < count; idx++) begin
            flush = (stencil_sb.stream_pos >= n * n * n);
            if ($urandom_range(0, 15) == 0) flush = !flush;
            case ($urandom_range(0, 7))
                0: val = 32'h7FFF_FFFF;
                1: val = 32'h8000_0000;
                2: val = $urandom_range(0, 511) - 256;
                3: val = 32'h7FFF_FF00 | $urandom_range(0, 255);
                4: val = 32'h8000_0000 | $urandom_range(0, 255);
                5, 6: val = $urandom_range(0, 67108863) - 33554432;
                default: val = $urandom;
            endcase
            send_word(val, flush);
        end
    endtask

    // Stop sending, wait for every owed update, then let the pipeline empty.
    task automatic wait_for_idle();
        s_tvalid <= 1'b0;
        while (stencil_sb.pending_updates.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Register write; the caller lowers cfg_valid after its last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        stencil_sb.write_reg(idx, val);
    endtask

    initial begin : stimulus
        logic [DATA_W:0]         opening [0:22];
        logic [COEF_W-1:0]       coef_val;
        logic [GRID_FIELD_W-1:0] grid_val;
        int unsigned             random_words, n, total, count, k;

        stencil_sb = new();
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_COEF;
        cfg_data  <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed grid of edge 3 (written as 2, so clamped) with the largest
        // coefficient. The one inner voxel has the most negative center and
        // largest neighbors, one of them an early flush, so it saturates high.
        // A second early flush and the extremes of the sample sit around it.
        opening = '{33'h0_7FFF_FFFF, 33'h0_8000_0000, 33'h0_0000_0000, 33'h0_FFFF_FFFF,
                    33'h1_7FFF_FFFF, 33'h0_0000_0001, 33'h0_0100_0000, 33'h0_FF00_0000,
                    33'h0_5555_5555, 33'h0_AAAA_AAAA, 33'h0_7FFF_FFFF, 33'h0_0000_0000,
                    33'h0_7FFF_FFFF, 33'h0_8000_0000, 33'h0_7FFF_FFFF, 33'h0_0000_0000,
                    33'h0_7FFF_FFFF, 33'h0_0080_0000, 33'h0_1234_5678, 33'h0_EDCB_A987,
                    33'h0_0000_0000, 33'h1_0000_0000, 33'h0_7FFF_FFFF};
        write_reg(REG_GRID, 24'd2);
        write_reg(REG_COEF, 24'hFF_FFFF);
        cfg_valid <= 1'b0;
        for (k = 0; k < 23; k++) begin
            send_word(opening[k][DATA_W-1:0], opening[k][DATA_W]);
        end
        // Rest of that grid: the last voxel words and the drain words, now and then with the flag flipped.
        send_stream(13);

        // Random phases over small grids and a spread of coefficients.
        random_words = 0;
        while (random_words < RANDOM_WORDS) begin
            wait_for_idle();
            case ($urandom_range(0, 5))
                0: coef_val = '0;
                1: coef_val = 24'hFF_FFFF;
                2: coef_val = COEF_RESET;
                3: coef_val = $urandom_range(0, 65535);
                4: coef_val = 24'd1;
                default: coef_val = $urandom;
            endcase
            case ($urandom_range(0, 7))
                0: grid_val = 7'd0;
                1: grid_val = 7'd1;
                2: grid_val = 7'd2;
                3, 4: grid_val = 7'd3;
                5: grid_val = 7'd4;
                6: grid_val = 7'd5;
                default: grid_val = 7'd6;
            endcase
            write_reg(REG_COEF, coef_val);
            // Now and then only the coefficient changes and the stream carries on.
            if ($urandom_range(0, 4) != 0) begin
                write_reg(REG_GRID, {17'($urandom), grid_val});
            end
            cfg_valid <= 1'b0;
            n = stencil_sb.grid_edge();
            total = n * n * n + n * n;
            count = $urandom_range(1, 2) * total;
            // A partial grid: the next size write must restart the stream.
            if ($urandom_range(0, 3) == 0) count = count + $urandom_range(1, total - 1);
            send_stream(count);
            random_words += count;
        end

        // Largest grid, reached by a clamped write: part of the first plane,
        // which must give no result.
        wait_for_idle();
        write_reg(REG_GRID, {17'($urandom), 7'd127});
        write_reg(REG_COEF, 24'($urandom));
        cfg_valid <= 1'b0;
        send_stream(MAX_GRID_WORDS);

        // Largest grid written exactly, which restarts the partial stream.
        wait_for_idle();
        write_reg(REG_GRID, 24'd64);
        write_reg(REG_COEF, 24'hFF_FFFF);
        cfg_valid <= 1'b0;
        send_stream(MAX_GRID_WORDS);

        wait_for_idle();
        if (stencil_sb.failures == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
